>>> rtl/executable_section_load_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Executable section load sequencer: assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef EXECUTABLE_SECTION_LOAD_SEQUENCER_DEFINES_SVH
`define EXECUTABLE_SECTION_LOAD_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ESLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ESLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/esls_pkg.sv
// ----------------------------------------------------------------------------
// Executable section load sequencer package
// Opcodes, register indexes, widths and the result record.
// ----------------------------------------------------------------------------
package esls_pkg;

    localparam int DEF_TEXT_SECTIONS = 7;
    localparam int DEF_DATA_SECTIONS = 11;

    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = 6;
    // Layout index: up to 3 * (16 + 16) + 2 entries
    localparam int HDR_IDX_W   = 7;
    // Section cursor: holds counts up to 16
    localparam int CUR_W       = 5;

    localparam logic [31:0] INFO_DISC_OFFSET = 32'h0000_0420;
    localparam logic [31:0] INFO_BYTES       = 32'd32;
    localparam logic [31:0] HEADER_BYTES     = 32'd256;
    localparam logic [31:0] ROUND_MASK       = 32'd31;

    typedef enum logic [1:0] {
        OP_NEXT      = 2'd0,
        OP_INFO_FILL = 2'd1,
        OP_HDR_FILL  = 2'd2,
        OP_UNUSED    = 2'd3
    } t_opcode;

    typedef enum logic {
        CFG_INFO_BUF = 1'b0,
        CFG_HDR_BUF  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic                read_request;
        logic [31:0]         dest_address;
        logic [31:0]         read_length;
        logic [31:0]         disc_offset;
        logic [31:0]         entry_point;
        logic                clear_bss;
        logic [31:0]         bss_address;
        logic [31:0]         bss_length;
    } t_result;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] idx;
        logic [31:0]         data;
    } t_store_wr;

endpackage

>>> rtl/esls_if.sv
// ----------------------------------------------------------------------------
// Executable section load sequencer channels
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface esls_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [5:0]  word_index;
    logic [31:0] word_value;

    modport source (output valid, opcode, word_index, word_value, input ready);
    modport sink   (input valid, opcode, word_index, word_value, output ready);
endinterface

interface esls_out_if;
    logic        valid;
    logic        ready;
    logic        read_request;
    logic [31:0] dest_address;
    logic [31:0] read_length;
    logic [31:0] disc_offset;
    logic [31:0] entry_point;
    logic        clear_bss;
    logic [31:0] bss_address;
    logic [31:0] bss_length;

    modport source (output valid, read_request, dest_address, read_length, disc_offset,
                    entry_point, clear_bss, bss_address, bss_length, input ready);
    modport sink   (input valid, read_request, dest_address, read_length, disc_offset,
                    entry_point, clear_bss, bss_address, bss_length, output ready);
endinterface

interface esls_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/esls_hdr_store.sv
// ----------------------------------------------------------------------------
// Header word store
// 64 x 32 synchronous memory with per-entry valid bits; one write port and
// one registered read port. Unwritten or out-of-range entries read as zero.
// ----------------------------------------------------------------------------
module esls_hdr_store
    import esls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_store_wr            i_wr,
    input  logic [HDR_IDX_W-1:0] i_rd_idx,
    output logic [31:0]          o_rd_data
);

    logic [31:0]            r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_valid;
    logic [31:0]            r_q;
    logic                   r_hit;
    logic                   rd_in_range;

    assign rd_in_range = (i_rd_idx < HDR_IDX_W'(STORE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        r_q <= r_mem[i_rd_idx[STORE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            r_hit <= rd_in_range && r_valid[i_rd_idx[STORE_AW-1:0]];
        end
    end

    assign o_rd_data = r_hit ? r_q : 32'd0;

endmodule

>>> rtl/executable_section_load_sequencer.sv
// ----------------------------------------------------------------------------
// Executable section load sequencer
// Answers each next request with one disc read command (disc info, header,
// then every nonzero text and data section) and finally the entry point, with
// a bss clear request when bss address and size are both nonzero.
// ----------------------------------------------------------------------------
// Header words live in a 64-entry synchronous store. A fill is handled in
// ST_IDLE. A next request in the info, header or done phase stages its result
// in ST_EMIT, which loads the output register once it is free. In the text and
// data phases each header entry is scanned in ST_SCAN (size read) and ST_SIZE
// (checked against the store's registered read port); a nonzero section adds
// two more reads (address, offset). The finish request scans all remaining
// entries, then reads entry, bss address and bss size. One request is worked
// on at a time; a pending result waits in the output register while the next
// request is accepted. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`include "executable_section_load_sequencer_defines.svh"

module executable_section_load_sequencer
    import esls_pkg::*;
#(
    parameter int TEXT_SECTIONS = DEF_TEXT_SECTIONS,
    parameter int DATA_SECTIONS = DEF_DATA_SECTIONS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esls_in_if.sink    i_in,
    esls_cfg_if.sink   i_cfg,
    esls_out_if.source o_res
);

    localparam int SECTS = TEXT_SECTIONS + DATA_SECTIONS;

    localparam logic [HDR_IDX_W-1:0] TXT_OFF_BASE  = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] DAT_OFF_BASE  = HDR_IDX_W'(TEXT_SECTIONS);
    localparam logic [HDR_IDX_W-1:0] TXT_ADDR_BASE = HDR_IDX_W'(SECTS);
    localparam logic [HDR_IDX_W-1:0] DAT_ADDR_BASE = HDR_IDX_W'(SECTS + TEXT_SECTIONS);
    localparam logic [HDR_IDX_W-1:0] TXT_SIZE_BASE = HDR_IDX_W'(2 * SECTS);
    localparam logic [HDR_IDX_W-1:0] DAT_SIZE_BASE = HDR_IDX_W'(2 * SECTS + TEXT_SECTIONS);
    localparam logic [HDR_IDX_W-1:0] BSS_ADDR_IDX  = HDR_IDX_W'(3 * SECTS);
    localparam logic [HDR_IDX_W-1:0] BSS_SIZE_IDX  = HDR_IDX_W'(3 * SECTS + 1);
    localparam logic [HDR_IDX_W-1:0] ENTRY_IDX     = HDR_IDX_W'(3 * SECTS + 2);
    localparam logic [CUR_W-1:0]     TEXT_CNT      = CUR_W'(TEXT_SECTIONS);
    localparam logic [CUR_W-1:0]     DATA_CNT      = CUR_W'(DATA_SECTIONS);

    typedef enum logic [2:0] {
        PH_INFO, PH_HEADER, PH_TEXT, PH_DATA, PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SIZE, ST_ADDR, ST_OFF,
        ST_FIN_ENTRY, ST_FIN_BSS_ADDR, ST_FIN_BSS_SIZE, ST_EMIT
    } t_state;

    t_state               r_state;
    t_phase               r_phase;
    logic [CUR_W-1:0]     r_cursor;
    logic [31:0]          r_exec_off;
    logic [31:0]          r_saved_entry;
    logic [31:0]          r_info_buf;
    logic [31:0]          r_hdr_buf;
    t_result              r_res;
    t_result              r_out;
    logic                 r_out_valid;

    logic                 in_fire;
    logic                 out_free;
    logic                 grp_data;
    logic [CUR_W-1:0]     grp_cnt;
    logic [HDR_IDX_W-1:0] off_base;
    logic [HDR_IDX_W-1:0] addr_base;
    logic [HDR_IDX_W-1:0] size_base;
    logic [HDR_IDX_W-1:0] rd_idx;
    logic [31:0]          rd_data;
    t_store_wr            st_wr;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign grp_data  = (r_phase == PH_DATA);
    assign grp_cnt   = grp_data ? DATA_CNT : TEXT_CNT;
    assign off_base  = grp_data ? DAT_OFF_BASE : TXT_OFF_BASE;
    assign addr_base = grp_data ? DAT_ADDR_BASE : TXT_ADDR_BASE;
    assign size_base = grp_data ? DAT_SIZE_BASE : TXT_SIZE_BASE;

    assign st_wr.en   = in_fire && (t_opcode'(i_in.opcode) == OP_HDR_FILL);
    assign st_wr.idx  = i_in.word_index;
    assign st_wr.data = i_in.word_value;

    // Read address for the data consumed in the following state
    always_comb begin
        case (r_state)
            ST_SCAN: begin
                rd_idx = (r_cursor < grp_cnt) ? (size_base + HDR_IDX_W'(r_cursor))
                                              : ENTRY_IDX;
            end
            ST_SIZE:         rd_idx = addr_base + HDR_IDX_W'(r_cursor);
            ST_ADDR:         rd_idx = off_base + HDR_IDX_W'(r_cursor);
            ST_FIN_ENTRY:    rd_idx = BSS_ADDR_IDX;
            ST_FIN_BSS_ADDR: rd_idx = BSS_SIZE_IDX;
            default:         rd_idx = '0;
        endcase
    end

    esls_hdr_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (st_wr),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_info_buf <= '0;
            r_hdr_buf  <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_index'(i_cfg.index))
                CFG_INFO_BUF: r_info_buf <= i_cfg.data;
                CFG_HDR_BUF:  r_hdr_buf  <= i_cfg.data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= PH_INFO;
            r_cursor      <= '0;
            r_exec_off    <= '0;
            r_saved_entry <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // drain the output register; a staged result refills it in ST_EMIT
            if (r_out_valid && o_res.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (t_opcode'(i_in.opcode))
                            OP_INFO_FILL: begin
                                if (i_in.word_index == '0) begin
                                    r_exec_off <= i_in.word_value;
                                end
                            end
                            OP_NEXT: begin
                                case (r_phase)
                                    PH_INFO: begin
                                        r_res   <= '{read_request: 1'b1,
                                                     dest_address: r_info_buf,
                                                     read_length:  INFO_BYTES,
                                                     disc_offset:  INFO_DISC_OFFSET,
                                                     default:      '0};
                                        r_phase <= PH_HEADER;
                                        r_state <= ST_EMIT;
                                    end
                                    PH_HEADER: begin
                                        r_res    <= '{read_request: 1'b1,
                                                      dest_address: r_hdr_buf,
                                                      read_length:  HEADER_BYTES,
                                                      disc_offset:  r_exec_off,
                                                      default:      '0};
                                        r_phase  <= PH_TEXT;
                                        r_cursor <= '0;
                                        r_state  <= ST_EMIT;
                                    end
                                    PH_TEXT, PH_DATA: begin
                                        r_res   <= '0;
                                        r_state <= ST_SCAN;
                                    end
                                    default: begin
                                        // finished: repeat entry, no bss clear
                                        r_res   <= '{entry_point: r_saved_entry,
                                                     default:     '0};
                                        r_state <= ST_EMIT;
                                    end
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_cursor < grp_cnt) begin
                        r_state <= ST_SIZE;
                    end else if (!grp_data) begin
                        // text group exhausted: move on to data
                        r_phase  <= PH_DATA;
                        r_cursor <= '0;
                    end else begin
                        r_state <= ST_FIN_ENTRY;
                    end
                end
                ST_SIZE: begin
                    if (rd_data == 32'd0) begin
                        r_cursor <= r_cursor + CUR_W'(1);
                        r_state  <= ST_SCAN;
                    end else begin
                        r_res.read_length <= (rd_data + ROUND_MASK) & ~ROUND_MASK;
                        r_state           <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_res.dest_address <= rd_data;
                    r_state            <= ST_OFF;
                end
                ST_OFF: begin
                    r_res.read_request <= 1'b1;
                    r_res.disc_offset  <= r_exec_off + rd_data;
                    r_cursor           <= r_cursor + CUR_W'(1);
                    r_state            <= ST_EMIT;
                end
                ST_FIN_ENTRY: begin
                    r_saved_entry <= rd_data;
                    r_state       <= ST_FIN_BSS_ADDR;
                end
                ST_FIN_BSS_ADDR: begin
                    // hold bss address until the size is known
                    r_res.bss_address <= rd_data;
                    r_state           <= ST_FIN_BSS_SIZE;
                end
                ST_FIN_BSS_SIZE: begin
                    r_res.read_request <= 1'b0;
                    r_res.dest_address <= '0;
                    r_res.read_length  <= '0;
                    r_res.disc_offset  <= '0;
                    r_res.entry_point  <= r_saved_entry;
                    if ((r_res.bss_address != 32'd0) && (rd_data != 32'd0)) begin
                        r_res.clear_bss  <= 1'b1;
                        r_res.bss_length <= rd_data;
                    end else begin
                        r_res.clear_bss   <= 1'b0;
                        r_res.bss_address <= '0;
                        r_res.bss_length  <= '0;
                    end
                    r_phase <= PH_DONE;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.read_request = r_out.read_request;
    assign o_res.dest_address = r_out.dest_address;
    assign o_res.read_length  = r_out.read_length;
    assign o_res.disc_offset  = r_out.disc_offset;
    assign o_res.entry_point  = r_out.entry_point;
    assign o_res.clear_bss    = r_out.clear_bss;
    assign o_res.bss_address  = r_out.bss_address;
    assign o_res.bss_length   = r_out.bss_length;

    `ESLS_ASSERT_IMP(a_len_aligned, i_clk, i_rst_n,
        r_out_valid && r_out.read_request, r_out.read_length[4:0] == 5'd0,
        "read length not a multiple of 32")
    `ESLS_ASSERT_IMP(a_bss_on_finish, i_clk, i_rst_n,
        r_out_valid && r_out.clear_bss,
        !r_out.read_request && (r_out.bss_address != 32'd0) && (r_out.bss_length != 32'd0),
        "bss clear outside a finish result")
    `ESLS_ASSERT_IMP(a_finish_phase, i_clk, i_rst_n,
        r_out_valid && !r_out.read_request, r_phase == PH_DONE,
        "finish result before done phase")
    `ESLS_ASSERT_IMP(a_cursor_bound, i_clk, i_rst_n,
        (r_state == ST_SIZE) || (r_state == ST_ADDR) || (r_state == ST_OFF),
        r_cursor < grp_cnt, "section cursor beyond its group")
    `ESLS_ASSERT_NXT(a_off_emits, i_clk, i_rst_n,
        r_state == ST_OFF, (r_state == ST_EMIT) && r_res.read_request,
        "section read not staged for output")

endmodule
